FILE: hdl/rtcm2_word_deframer_unit_defines.svh
// ----------------------------------------------------------------------------
// RTCM 2 word deframer: assertion macros
// Shared check macros, clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RTCM2_WORD_DEFRAMER_UNIT_DEFINES_SVH
`define RTCM2_WORD_DEFRAMER_UNIT_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define RWD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication form: antecedent holds, consequent must hold on the next edge.
`define RWD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/rwd_pkg.sv
// ----------------------------------------------------------------------------
// rwd_pkg
// Types, codes and constants of the RTCM 2 word deframer.
// ----------------------------------------------------------------------------
package rwd_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_WAIT    = 2'd0,
        ST_DONE    = 2'd1,
        ST_REJECT  = 2'd2,
        ST_LEN_ERR = 2'd3
    } t_status;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PREAMBLE  = 2'd0,
        CFG_MIN_BYTES = 2'd1,
        CFG_MAX_BYTES = 2'd2
    } t_cfg_idx;

    localparam logic [7:0]  PREAMBLE_RST  = 8'd102;
    localparam logic [7:0]  MIN_BYTES_RST = 8'd5;
    localparam logic [7:0]  MAX_BYTES_RST = 8'd99;

    localparam logic [1:0]  BYTE_TAG      = 2'b01;
    localparam int          BITS_PER_BYTE = 6;
    localparam logic [4:0]  WORD_LAST_BIT = 5'd30;
    localparam logic [5:0]  HEADER_WORDS  = 6'd2;
    localparam logic [6:0]  FRAME_BASE    = 7'd6;
    localparam logic [31:0] D30_INVERT    = 32'h3FFF_FFC0;
    localparam logic [31:0] PARITY_BITS   = 32'hFFFF_FFC0;

    localparam logic [31:0] PARITY_MASK [6] = '{
        32'hBB1F_3480, 32'h5D8F_9A40, 32'hAEC7_CD00,
        32'h5763_E680, 32'h6BB1_F340, 32'h8B7A_89C0
    };

    typedef struct packed {
        logic [7:0] preamble;
        logic [7:0] min_bytes;
        logic [7:0] max_bytes;
    } t_cfg;

    typedef struct packed {
        logic [31:0] shift_word;
        logic [5:0]  word_cnt;    // 0 means unsynced
        logic [4:0]  bit_cnt;
        logic [6:0]  frame_len;
        logic [1:0]  last_word;
    } t_state;

    typedef struct packed {
        t_status     status;
        logic        word_valid;
        logic [23:0] word_data;
        logic [5:0]  word_index;
        logic        frame_dropped;
        logic [6:0]  frame_bytes;
    } t_result;

    typedef struct packed {
        logic        ok;
        logic [23:0] data;
    } t_check;

    // GPS parity over D29*, D30* and D1..D24; data polarity fixed by D30*
    function automatic t_check check_word(logic [31:0] w_in);
        logic [31:0] w;
        logic [5:0]  par;
        t_check      res;
        w = w_in[30] ? (w_in ^ D30_INVERT) : w_in;
        for (int k = 0; k < 6; k++) begin
            par[5 - k] = ^(w & PARITY_MASK[k] & PARITY_BITS);
        end
        res.ok   = (par == w[5:0]);
        res.data = w[29:6];
        return res;
    endfunction

endpackage

FILE: hdl/rtcm2_word_deframer_unit.sv
// ----------------------------------------------------------------------------
// rtcm2_word_deframer_unit
// RTCM 2 deframer: hunts the preamble, checks GPS parity, reports words.
// ----------------------------------------------------------------------------
// channel  | dir | request
// s_axis   | in  | one 6-of-8 byte, tdata[7:0]
// m_axis   | out | one result per byte, status in tuser
// cfg      | in  | register write, index and 8-bit data
//
// One byte per cycle sustained while the result side accepts; a byte is taken
// into the input register, processed from there, and its result registered.
// The six bit steps of a byte are one pass of logic.
// Reset clears frame state and loads the register defaults.
// Input register and result register decouple the two sides under stalls.
// ----------------------------------------------------------------------------
`include "rtcm2_word_deframer_unit_defines.svh"

module rtcm2_word_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] word_valid, [24:1] word_data, [30:25] word_index,
    // [31] frame_dropped, [38:32] frame_bytes, [39] zero
    output logic [39:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser,   // [1:0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    rwd_pkg::t_cfg    r_cfg;
    rwd_pkg::t_state  r_state, n_state;
    rwd_pkg::t_result r_out, n_out;
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    logic             advance;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preamble  <= rwd_pkg::PREAMBLE_RST;
            r_cfg.min_bytes <= rwd_pkg::MIN_BYTES_RST;
            r_cfg.max_bytes <= rwd_pkg::MAX_BYTES_RST;
        end else if (i_cfg_valid) begin
            case (rwd_pkg::t_cfg_idx'(i_cfg_index))
                rwd_pkg::CFG_PREAMBLE:  r_cfg.preamble  <= i_cfg_data;
                rwd_pkg::CFG_MIN_BYTES: r_cfg.min_bytes <= i_cfg_data;
                rwd_pkg::CFG_MAX_BYTES: r_cfg.max_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    rwd_byte_step u_step (
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {1'b0, r_out.frame_bytes, r_out.frame_dropped,
                              r_out.word_index, r_out.word_data, r_out.word_valid};

    `RWD_ASSERT(a_reject_clean,
        !(r_out_valid && r_out.status == rwd_pkg::ST_REJECT) || o_m_axis_tdata == '0,
        "rejected byte carries nonzero fields")
    `RWD_ASSERT(a_fbytes_only_done,
        !(r_out_valid && r_out.status != rwd_pkg::ST_DONE) || r_out.frame_bytes == '0,
        "frame_bytes set without frame complete")
    `RWD_ASSERT(a_index_needs_word,
        !r_out_valid || r_out.word_valid || r_out.word_index == '0,
        "word_index set without a valid word")
    `RWD_ASSERT_NEXT(a_sync_bits, r_state.word_cnt == '0, r_state.bit_cnt == '0 ||
        r_state.word_cnt != '0, "bit counter running while unsynced")

endmodule

FILE: hdl/rwd_byte_step.sv
// ----------------------------------------------------------------------------
// rwd_byte_step
// Tag check and up to six bit steps of hunt, parity check and framing for one byte.
// ----------------------------------------------------------------------------
module rwd_byte_step (
    input  logic [7:0]      i_byte,
    input  rwd_pkg::t_cfg   i_cfg,
    input  rwd_pkg::t_state i_state,
    output rwd_pkg::t_state o_state,
    output rwd_pkg::t_result o_result
);

    rwd_pkg::t_state  st;
    rwd_pkg::t_result res;
    rwd_pkg::t_check  chk;
    logic             done;
    logic [7:0]       pre;
    logic [6:0]       nbytes;

    always_comb begin
        st     = i_state;
        res    = '0;
        chk    = '0;
        done   = 1'b0;
        pre    = '0;
        nbytes = '0;
        if (i_byte[7:6] != rwd_pkg::BYTE_TAG) begin
            res.status = rwd_pkg::ST_REJECT;
        end else begin
            for (int i = 0; i < rwd_pkg::BITS_PER_BYTE; i++) begin
                if (!done) begin
                    st.shift_word = {st.shift_word[30:0], i_byte[i]};
                    chk = rwd_pkg::check_word(st.shift_word);
                    if (st.word_cnt == '0) begin
                        // hunting: preamble and parity on every bit
                        pre = st.shift_word[29:22] ^ {8{st.shift_word[30]}};
                        if (pre == i_cfg.preamble && chk.ok) begin
                            res.word_valid = 1'b1;
                            res.word_data  = chk.data;
                            res.word_index = '0;
                            st.word_cnt    = 6'd1;
                            st.bit_cnt     = '0;
                        end
                    end else begin
                        st.bit_cnt = st.bit_cnt + 5'd1;
                        if (st.bit_cnt == rwd_pkg::WORD_LAST_BIT) begin
                            st.bit_cnt = '0;
                            if (!chk.ok) begin
                                st.word_cnt       = '0;
                                st.shift_word     = {30'd0, st.shift_word[1:0]};
                                res.frame_dropped = 1'b1;
                            end else begin
                                res.word_valid = 1'b1;
                                res.word_data  = chk.data;
                                res.word_index = st.word_cnt;
                                st.word_cnt    = st.word_cnt + 6'd1;
                                // three bytes per word
                                nbytes = {st.word_cnt, 1'b0} + {1'b0, st.word_cnt};
                                if (st.word_cnt == rwd_pkg::HEADER_WORDS) begin
                                    st.frame_len = {1'b0, chk.data[7:3], 1'b0}
                                                 + {2'b0, chk.data[7:3]}
                                                 + rwd_pkg::FRAME_BASE;
                                end
                                if (nbytes >= st.frame_len) begin
                                    done = 1'b1;
                                    if ({1'b0, nbytes} > i_cfg.max_bytes ||
                                        {1'b0, nbytes} <= i_cfg.min_bytes) begin
                                        st.frame_len  = '0;
                                        st.shift_word = {30'd0, st.last_word};
                                        st.word_cnt   = '0;
                                        res.status    = rwd_pkg::ST_LEN_ERR;
                                    end else begin
                                        res.frame_bytes = nbytes;
                                        st.word_cnt     = '0;
                                        st.last_word    = st.shift_word[1:0];
                                        st.shift_word   = {30'd0, st.shift_word[1:0]};
                                        res.status      = rwd_pkg::ST_DONE;
                                    end
                                end
                            end
                        end
                    end
                end
            end
        end
        o_state  = st;
        o_result = res;
    end

endmodule

FILE: verif/tb_rtcm2_word_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rtcm2_word_deframer_unit
// Self-checking bench for the RTCM 2 word deframer. Sends 6-of-8 bytes built
// as GPS-parity frames (clean, corrupted, shifted within the byte), noise and
// rejected bytes under several register settings, and compares every result
// against a bit-accurate model of the preamble hunt and word checks.
// ----------------------------------------------------------------------------
module tb_rtcm2_word_deframer_unit;

    localparam logic [1:0] CFG_SPARE_IDX = 2'd3;    // not a register, writes ignored
    localparam int         STALL_LIMIT   = 2000;
    localparam int         PHASE_BYTES   = 55;

    // ------------------------------------------------------------------------
    // Scoreboard: models the deframer and holds the results due per byte
    // ------------------------------------------------------------------------
    class word_deframe_scoreboard;
        logic [7:0]       preamble_cfg;
        logic [7:0]       min_cfg;
        logic [7:0]       max_cfg;
        logic [31:0]      shift_word;
        logic [6:0]       byte_count;     // 0 while hunting
        logic [4:0]       bit_count;
        logic [6:0]       frame_length;
        logic [1:0]       last_word;
        rwd_pkg::t_result due[$];
        int               mismatches;

        function new();
            preamble_cfg = rwd_pkg::PREAMBLE_RST;
            min_cfg      = rwd_pkg::MIN_BYTES_RST;
            max_cfg      = rwd_pkg::MAX_BYTES_RST;
            shift_word   = '0;
            byte_count   = '0;
            bit_count    = '0;
            frame_length = '0;
            last_word    = '0;
            mismatches   = 0;
        endfunction

        static function logic [5:0] parity_of(input logic [31:0] w);
            logic [5:0] p;
            p = '0;
            for (int k = 0; k < 6; k++) begin
                p = {p[4:0], ^(w[31:6] & rwd_pkg::PARITY_MASK[k][31:6])};
            end
            return p;
        endfunction

        function bit word_ok(input logic [31:0] w_in, output logic [23:0] data);
            logic [31:0] w;
            w    = w_in[30] ? (w_in ^ rwd_pkg::D30_INVERT) : w_in;
            data = w[29:6];
            return parity_of(w) == w[5:0];
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [7:0] val);
            case (idx)
                rwd_pkg::CFG_PREAMBLE:  preamble_cfg = val;
                rwd_pkg::CFG_MIN_BYTES: min_cfg      = val;
                rwd_pkg::CFG_MAX_BYTES: max_cfg      = val;
                default: ;
            endcase
        endfunction

        function void predict_byte(input logic [7:0] rx);
            rwd_pkg::t_result r;
            logic [5:0]       bits;
            logic [7:0]       pre;
            logic [23:0]      d;
            bit               done;
            r        = '0;
            r.status = rwd_pkg::ST_WAIT;
            done     = 1'b0;
            bits     = rx[5:0];
            if (rx[7:6] != rwd_pkg::BYTE_TAG) begin
                r.status = rwd_pkg::ST_REJECT;
            end else begin
                for (int i = 0; i < rwd_pkg::BITS_PER_BYTE && !done; i++) begin
                    shift_word = {shift_word[30:0], bits[i]};
                    if (byte_count == 0) begin
                        pre = shift_word[29:22] ^ {8{shift_word[30]}};
                        if (pre == preamble_cfg && word_ok(shift_word, d)) begin
                            r.word_valid = 1'b1;
                            r.word_data  = d;
                            r.word_index = '0;
                            byte_count   = 7'd3;
                            bit_count    = '0;
                        end
                    end else begin
                        bit_count = bit_count + 5'd1;
                        if (bit_count >= rwd_pkg::WORD_LAST_BIT) begin
                            bit_count = '0;
                            if (!word_ok(shift_word, d)) begin
                                // frame lost; hunt again from the next bit
                                byte_count      = '0;
                                shift_word      = {30'd0, shift_word[1:0]};
                                r.frame_dropped = 1'b1;
                            end else begin
                                r.word_valid = 1'b1;
                                r.word_data  = d;
                                r.word_index = 6'(byte_count / 7'd3);
                                byte_count   = byte_count + 7'd3;
                                if (byte_count == 7'd6)
                                    frame_length = 7'(d[7:3]) * 7'd3 + rwd_pkg::FRAME_BASE;
                                if (byte_count >= frame_length) begin
                                    if (byte_count > max_cfg || byte_count <= min_cfg) begin
                                        frame_length = '0;
                                        shift_word   = {30'd0, last_word};
                                        byte_count   = '0;
                                        bit_count    = '0;
                                        r.status     = rwd_pkg::ST_LEN_ERR;
                                    end else begin
                                        r.frame_bytes = byte_count;
                                        byte_count    = '0;
                                        last_word     = shift_word[1:0];
                                        shift_word    = {30'd0, shift_word[1:0]};
                                        r.status      = rwd_pkg::ST_DONE;
                                    end
                                    done = 1'b1;   // rest of the byte is dropped
                                end
                            end
                        end
                    end
                end
            end
            due.push_back(r);
        endfunction

        function void check_result(input logic [39:0] tdata, input logic [1:0] tuser);
            rwd_pkg::t_result e;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: st=%0d data=%010h", tuser, tdata);
                return;
            end
            e = due.pop_front();
            if (tuser != e.status || tdata[0] != e.word_valid
                    || tdata[24:1] != e.word_data || tdata[30:25] != e.word_index
                    || tdata[31] != e.frame_dropped || tdata[38:32] != e.frame_bytes) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t result error: exp st=%0d wv=%0d wd=%06h wi=%0d drop=%0d fb=%0d",
                             $realtime, e.status, e.word_valid, e.word_data, e.word_index,
                             e.frame_dropped, e.frame_bytes);
                    $display("    got st=%0d wv=%0d wd=%06h wi=%0d drop=%0d fb=%0d",
                             tuser, tdata[0], tdata[24:1], tdata[30:25], tdata[31],
                             tdata[38:32]);
                end
            end
        endfunction

        function void leftover_check();
            if (due.size() != 0) begin
                if (mismatches < 10)
                    $display("%0d results never arrived", due.size());
                mismatches += due.size();
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_valid  = 1'b0;
    logic [7:0]  s_data   = '0;
    logic        m_ready  = 1'b0;
    logic        c_valid  = 1'b0;
    logic [1:0]  c_index  = '0;
    logic [7:0]  c_data   = '0;
    logic        no_gaps  = 1'b0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [39:0] o_m_axis_tdata;
    wire  [1:0]  o_m_axis_tuser;
    wire         o_cfg_ready;

    word_deframe_scoreboard sb = new();
    logic [7:0] tx_bytes[$];
    int         sent_count  = 0;
    int         idle_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    rtcm2_word_deframer_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (c_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (c_index),
        .i_cfg_data      (c_data)
    );

    // result side: random backpressure unless no_gaps is set, check on every handshake
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_ready)
                sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
            m_ready <= no_gaps || ($urandom_range(0, 99) >= 29);
        end
    end

    // no request moving on any channel for too long ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)
                || (c_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        while (!no_gaps && $urandom_range(0, 99) < 29) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.predict_byte(b);
        sent_count++;
    endtask

    function automatic logic [7:0] reject_byte();
        logic [1:0] tag;
        tag = 2'($urandom_range(0, 2));
        if (tag == rwd_pkg::BYTE_TAG)
            tag = 2'b11;
        return {tag, 6'($urandom_range(0, 63))};
    endfunction

    // Encodes a frame of code+2 words after lead_bits random bits, continuing
    // from the D29*/D30* the block holds now. bad_word gets one bit flipped.
    function automatic void build_frame(input logic [4:0] code, input int lead_bits,
                                        input int bad_word);
        logic [1:0]  prev;
        logic [23:0] d;
        logic [29:0] tx;
        logic [5:0]  chunk;
        bit          b;
        bit          bits_q[$];
        int          flip;
        prev = sb.shift_word[1:0];
        repeat (lead_bits) begin
            b = 1'($urandom_range(0, 1));
            bits_q.push_back(b);
            prev = {prev[0], b};
        end
        for (int n = 0; n < int'(code) + 2; n++) begin
            d = 24'($urandom);
            if (n == 0)
                d[23:16] = sb.preamble_cfg;
            if (n == 1)
                d[7:3] = code;
            tx = {d ^ {24{prev[0]}},
                  word_deframe_scoreboard::parity_of({prev, d, 6'd0})};
            if (n == bad_word) begin
                flip     = $urandom_range(0, 29);
                tx[flip] = ~tx[flip];
            end
            for (int k = 29; k >= 0; k--)
                bits_q.push_back(tx[k]);
            prev = tx[1:0];
        end
        while (bits_q.size() % rwd_pkg::BITS_PER_BYTE != 0)
            bits_q.push_back(1'($urandom_range(0, 1)));
        while (bits_q.size() > 0) begin
            for (int k = 0; k < rwd_pkg::BITS_PER_BYTE; k++)
                chunk[k] = bits_q.pop_front();
            tx_bytes.push_back({rwd_pkg::BYTE_TAG, chunk});
        end
    endfunction

    // rejected bytes may land anywhere, even inside a frame
    task automatic send_queued();
        logic [7:0] b;
        while (tx_bytes.size() > 0) begin
            if ($urandom_range(0, 99) < 4)
                push_byte(reject_byte());
            b = tx_bytes.pop_front();
            push_byte(b);
        end
    endtask

    task automatic random_traffic(input int n_bytes);
        int         stop_at;
        int         pick;
        logic [4:0] code;
        stop_at = sent_count + n_bytes;
        while (sent_count < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                code = 5'd31;
            else if (pick < 10)
                code = 5'($urandom_range(6, 30));
            else
                code = 5'($urandom_range(0, 5));
            pick = $urandom_range(0, 99);
            if (pick < 70)
                build_frame(code, $urandom_range(0, 5), -1);
            else if (pick < 84)
                build_frame(code, $urandom_range(0, 5), $urandom_range(0, code + 1));
            else if (pick < 94)
                repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom));
            else
                tx_bytes.push_back(reject_byte());
            send_queued();
        end
    endtask

    // wait until every result is back and the pipeline is empty
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        c_valid <= 1'b1;
        c_index <= idx;
        c_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(input logic [7:0] pre, input logic [7:0] lo,
                             input logic [7:0] hi);
        write_reg(rwd_pkg::CFG_PREAMBLE, pre);
        write_reg(rwd_pkg::CFG_MIN_BYTES, lo);
        write_reg(rwd_pkg::CFG_MAX_BYTES, hi);
        write_reg(CFG_SPARE_IDX, 8'($urandom));
        c_valid <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // field extremes, then a clean frame ending mid-byte, then a bad word 1
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'hC0);
        push_byte(8'h40);
        push_byte(8'h7F);
        build_frame(5'd0, 3, -1);
        send_queued();
        build_frame(5'd0, 0, 1);
        send_queued();

        random_traffic(PHASE_BYTES);
        for (int ph = 1; ph <= 5; ph++) begin
            drain();
            no_gaps <= (ph == 3);
            case (ph)
                1: configure(8'h00, 8'h00, 8'hFF);
                2: configure(8'hFF, 8'hFF, 8'hFF);    // every frame is a length error
                3: configure(8'($urandom), 8'($urandom_range(6, 30)),
                             8'($urandom_range(20, 80)));
                4: configure(rwd_pkg::PREAMBLE_RST, 8'h00, 8'h00);
                default: configure(rwd_pkg::PREAMBLE_RST, rwd_pkg::MIN_BYTES_RST,
                                   rwd_pkg::MAX_BYTES_RST);
            endcase
            random_traffic(PHASE_BYTES);
        end

        drain();
        repeat (8) @(posedge i_clk);
        sb.leftover_check();
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/rwd_pkg.sv
hdl/rwd_byte_step.sv
hdl/rtcm2_word_deframer_unit.sv
verif/tb_rtcm2_word_deframer_unit.sv
